// ===== design/complex_rpn_stack_alu_macros.svh =====
// Assertion macros for the complex RPN stack ALU.
// Used by the top level only; no dependencies.
`ifndef COMPLEX_RPN_STACK_ALU_MACROS_SVH
`define COMPLEX_RPN_STACK_ALU_MACROS_SVH
`define CRSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define CRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

// ===== design/crsa_pkg.sv =====
// Package for the complex RPN stack ALU: op codes, status codes, types.
// No dependencies.
`default_nettype none
package crsa_pkg;
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_NEG  = 3'd5;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FEW  = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic signed [31:0] push_real;
        logic signed [31:0] push_imag;
    } t_in;

    typedef struct packed {
        logic signed [31:0] top_real;
        logic signed [31:0] top_imag;
        logic [4:0]  depth;
        logic [2:0]  status;
    } t_out;

    // clamp a sign-magnitude value to int32
    function automatic logic [32:0] fit32(input logic neg, input logic [64:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > 65'h80000000) r = {1'b1, 32'h80000000};
            else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
        end else begin
            if (mag > 65'h7FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
            else r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/crsa_if.sv =====
// Valid/ready channel interfaces for the complex RPN stack ALU.
// Depends on crsa_pkg.
`default_nettype none
interface crsa_in_if import crsa_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crsa_out_if import crsa_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/crsa_div.sv =====
// Restoring divider: floor(n * 2^16 / d), one quotient bit a cycle.
// No dependencies. Result capped at 2^32 when above 2^31.
`default_nettype none
module crsa_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [32:0]      o_quo
);
    logic [63:0] r_rem;
    logic [79:0] r_num;
    logic [63:0] r_den;
    logic [32:0] r_q;
    logic        r_ovf;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_trial;
    logic [64:0] n_diff;

    always_comb begin
        n_trial = {r_rem, r_num[79]};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_num  <= {i_num, 16'd0};
                r_den  <= i_den;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= 7'd79;
            end else if (r_busy) begin
                r_num <= {r_num[78:0], 1'b0};
                if (!n_diff[64]) r_rem <= n_diff[63:0];
                else r_rem <= n_trial[63:0];
                if (r_q[32] || r_ovf) r_ovf <= 1'b1;
                r_q <= {r_q[31:0], ~n_diff[64]};
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_ovf || r_q > 33'h080000000) ? 33'h100000000 : r_q;
endmodule
`default_nettype wire

// ===== design/complex_rpn_stack_alu.sv =====
// Complex RPN stack ALU: one operation per transaction, one result per transaction.
// Multiply forms four products through one 32x32 multiplier; divide forms six products,
// then runs the shared restoring divider once for each part; divide by zero skips the
// divider. A stalled result keeps the block busy until it is taken. The block is not
// ready while busy.
// Depends on crsa_pkg, crsa_if, crsa_div and complex_rpn_stack_alu_macros.svh.
`default_nettype none
`include "complex_rpn_stack_alu_macros.svh"
module complex_rpn_stack_alu import crsa_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crsa_in_if.sink   i_in,
    crsa_out_if.source o_out
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RDT   = 13'b0000000000010,
        S_TOP   = 13'b0000000000100,
        S_RDS   = 13'b0000000001000,
        S_RDB   = 13'b0000000010000,
        S_LDB   = 13'b0000000100000,
        S_ALU   = 13'b0000001000000,
        S_RND   = 13'b0000010000000,
        S_DCHK  = 13'b0000100000000,
        S_DSTR  = 13'b0001000000000,
        S_DWAIT = 13'b0010000000000,
        S_WR    = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    logic [31:0] r_mem_re [STACK_DEPTH];
    logic [31:0] r_mem_im [STACK_DEPTH];
    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic [2:0]  r_op;
    logic [2:0]  r_status;
    logic [31:0] r_rd_re, r_rd_im;
    logic signed [31:0] r_br, r_bi, r_ar, r_ai;
    logic [2:0]  r_mstep;
    logic signed [63:0] r_prod;
    logic signed [64:0] r_acc_re, r_acc_im, r_acc_d;
    logic [31:0] r_res_re, r_res_im;
    logic        r_sat;
    logic        r_dpart;
    logic        r_ovalid;
    t_out        r_odata;

    logic [AW-1:0] w_top, w_sec, w_raddr, w_waddr;
    logic        w_push;
    logic signed [31:0] w_ma, w_mb;
    logic signed [64:0] w_p65;
    logic signed [64:0] w_ar65, w_ai65, w_br65, w_bi65;
    logic signed [64:0] w_tre65, w_tim65;
    logic [32:0] w_neg_re, w_neg_im;
    logic [32:0] w_rnd_re, w_rnd_im;
    logic signed [64:0] w_dacc;
    logic        w_dneg;
    logic [64:0] w_dmag;
    logic        w_dstart;
    logic        w_ddone;
    logic [32:0] w_quo;
    logic [32:0] w_dfit;

    // saturate an exact signed value to Q16.16, bit 32 flags saturation
    function automatic logic [32:0] sat65(input logic signed [64:0] v);
        logic [32:0] r;
        if (v > 65'sh0_0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFFFFFF};
        else if (v < 65'sh1_FFFF_FFFF_8000_0000) r = {1'b1, 32'h80000000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction

    assign w_top   = AW'(r_cnt - CW'(1));
    assign w_sec   = AW'(r_cnt - CW'(2));
    assign w_raddr = (r_state == S_RDS) ? w_sec : w_top;
    assign w_waddr = (r_op == OP_NEG) ? w_top : w_sec;
    assign w_push  = i_in.valid && i_in.ready && i_in.data.op == OP_PUSH
                     && r_cnt < CW'(STACK_DEPTH);

    assign w_ar65  = {{33{r_ar[31]}}, r_ar};
    assign w_ai65  = {{33{r_ai[31]}}, r_ai};
    assign w_br65  = {{33{r_br[31]}}, r_br};
    assign w_bi65  = {{33{r_bi[31]}}, r_bi};
    assign w_tre65 = {{33{r_rd_re[31]}}, r_rd_re};
    assign w_tim65 = {{33{r_rd_im[31]}}, r_rd_im};
    assign w_p65   = {r_prod[63], r_prod};

    assign w_neg_re = sat65(-w_tre65);
    assign w_neg_im = sat65(-w_tim65);
    assign w_rnd_re = sat65((r_op == OP_MUL) ? (r_acc_re >>> 16) : r_acc_re);
    assign w_rnd_im = sat65((r_op == OP_MUL) ? (r_acc_im >>> 16) : r_acc_im);

    // multiplier operand selection
    always_comb begin
        unique case (r_mstep)
            3'd0: begin w_ma = r_ar; w_mb = r_br; end
            3'd1: begin w_ma = r_ai; w_mb = r_bi; end
            3'd2: begin w_ma = r_ar; w_mb = r_bi; end
            3'd3: begin w_ma = r_ai; w_mb = r_br; end
            3'd4: begin w_ma = r_br; w_mb = r_br; end
            3'd5: begin w_ma = r_bi; w_mb = r_bi; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // divider operand: magnitude of the current numerator
    always_comb begin
        w_dacc = r_dpart ? r_acc_im : r_acc_re;
        w_dneg = w_dacc[64];
        w_dmag = w_dneg ? 65'(-w_dacc) : 65'(w_dacc);
    end
    assign w_dfit   = fit32(w_dneg, {32'd0, w_quo});
    assign w_dstart = (r_state == S_DSTR);

    crsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dmag[63:0]),
        .i_den   (r_acc_d[63:0]),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem_re[AW'(r_cnt)] <= i_in.data.push_real;
            r_mem_im[AW'(r_cnt)] <= i_in.data.push_imag;
        end else if (r_state == S_WR) begin
            r_mem_re[w_waddr] <= r_res_re;
            r_mem_im[w_waddr] <= r_res_im;
        end
        r_rd_re <= r_mem_re[w_raddr];
        r_rd_im <= r_mem_im[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.data.op;
                        r_status <= ST_OK;
                        r_state  <= S_RDT;
                        unique case (i_in.data.op) inside
                            OP_PUSH: begin
                                if (r_cnt < CW'(STACK_DEPTH)) r_cnt <= r_cnt + CW'(1);
                                else r_status <= ST_FULL;
                            end
                            OP_NEG: begin
                                if (r_cnt == '0) r_status <= ST_FEW;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (r_cnt < CW'(2)) r_status <= ST_FEW;
                                else r_state <= S_RDS;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDT: r_state <= S_TOP;
                S_TOP: begin
                    if (r_op == OP_NEG && r_status == ST_OK) begin
                        r_res_re <= w_neg_re[31:0];
                        r_res_im <= w_neg_im[31:0];
                        r_sat    <= w_neg_re[32] | w_neg_im[32];
                        r_state  <= S_WR;
                    end else begin
                        r_odata.top_real <= (r_cnt == '0) ? '0 : r_rd_re;
                        r_odata.top_imag <= (r_cnt == '0) ? '0 : r_rd_im;
                        r_odata.depth    <= 5'(r_cnt);
                        r_odata.status   <= r_status;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_RDS: r_state <= S_RDB;
                S_RDB: begin
                    r_ar    <= r_rd_re;
                    r_ai    <= r_rd_im;
                    r_state <= S_LDB;
                end
                S_LDB: begin
                    r_br     <= r_rd_re;
                    r_bi     <= r_rd_im;
                    r_mstep  <= 3'd0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    r_acc_d  <= '0;
                    r_state  <= S_ALU;
                end
                S_ALU: begin
                    if (r_op == OP_ADD || r_op == OP_SUB) begin
                        r_acc_re <= (r_op == OP_ADD) ? w_ar65 + w_br65 : w_ar65 - w_br65;
                        r_acc_im <= (r_op == OP_ADD) ? w_ai65 + w_bi65 : w_ai65 - w_bi65;
                        r_state  <= S_RND;
                    end else begin
                        // product of step k is accumulated at step k+1
                        r_prod  <= w_ma * w_mb;
                        r_mstep <= r_mstep + 3'd1;
                        case (r_mstep) inside
                            3'd1: r_acc_re <= r_acc_re + w_p65;
                            3'd2: r_acc_re <= (r_op == OP_MUL) ? r_acc_re - w_p65
                                                              : r_acc_re + w_p65;
                            3'd3: r_acc_im <= (r_op == OP_MUL) ? r_acc_im + w_p65
                                                              : r_acc_im - w_p65;
                            3'd4: r_acc_im <= r_acc_im + w_p65;
                            3'd5, 3'd6: r_acc_d <= r_acc_d + w_p65;
                            default: ;
                        endcase
                        if (r_op == OP_MUL && r_mstep == 3'd4) r_state <= S_RND;
                        if (r_op == OP_DIV && r_mstep == 3'd6) r_state <= S_DCHK;
                    end
                end
                S_RND: begin
                    r_res_re <= w_rnd_re[31:0];
                    r_res_im <= w_rnd_im[31:0];
                    r_sat    <= w_rnd_re[32] | w_rnd_im[32];
                    r_state  <= S_WR;
                end
                S_DCHK: begin
                    if (r_acc_d == '0) begin
                        r_odata.top_real <= r_br;
                        r_odata.top_imag <= r_bi;
                        r_odata.depth    <= 5'(r_cnt);
                        r_odata.status   <= ST_DIV0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_dpart <= 1'b0;
                        r_sat   <= 1'b0;
                        r_state <= S_DSTR;
                    end
                end
                S_DSTR: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_ddone) begin
                        if (!r_dpart) begin
                            r_res_re <= w_dfit[31:0];
                            r_sat    <= w_dfit[32];
                            r_dpart  <= 1'b1;
                            r_state  <= S_DSTR;
                        end else begin
                            r_res_im <= w_dfit[31:0];
                            r_sat    <= r_sat | w_dfit[32];
                            r_state  <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    if (r_op != OP_NEG) r_cnt <= r_cnt - CW'(1);
                    r_odata.top_real <= r_res_re;
                    r_odata.top_imag <= r_res_im;
                    r_odata.depth    <= (r_op == OP_NEG) ? 5'(r_cnt) : 5'(r_cnt - CW'(1));
                    r_odata.status   <= r_sat ? ST_SAT : ST_OK;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready = r_state == S_IDLE;
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_odata;

    `CRSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in.valid && i_in.ready, !i_in.ready)
    `CRSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.data))
    `CRSA_ASSERT_IMPL(a_depth_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH))
endmodule
`default_nettype wire

// ===== tb/sv/complex_rpn_stack_alu_test.sv =====
`timescale 1ns / 1ps
// Testbench for complex_rpn_stack_alu: random and directed stack operations, results
// checked against an in-bench predictor of the stack. Depends on crsa_pkg and crsa_if.
module complex_rpn_stack_alu_test;
    import crsa_pkg::*;

    localparam int          NUM_RANDOM = 1400;
    localparam int          IDLE_LIMIT = 6000;
    localparam int          DEPTH_MAX  = 16;
    localparam logic [2:0]  OP_RSV6    = 3'd6;
    localparam logic [2:0]  OP_RSV7    = 3'd7;
    localparam logic [31:0] Q_MAX      = 32'h7FFFFFFF;
    localparam logic [31:0] Q_MIN      = 32'h80000000;
    localparam logic [31:0] Q_ONE      = 32'h00010000;

    logic i_clk;
    logic i_rst_n;

    crsa_in_if  in_ch ();
    crsa_out_if out_ch ();

    complex_rpn_stack_alu dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_in  op_queue[$];
    t_out top_queue[$];
    logic [31:0] stk_re[DEPTH_MAX];
    logic [31:0] stk_im[DEPTH_MAX];
    int   stk_count;
    int   err_count;
    int   idle_cycles;
    int   send_gap;
    int   recv_stall;
    bit   send_busy_mode;
    bit   recv_busy_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // saturate a wide signed value to Q16.16
    function automatic logic [31:0] clamp_q16(input logic signed [65:0] v, inout logic sat);
        if (v > 66'sh7FFFFFFF) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < -66'sh80000000) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] div_q16(input logic signed [65:0] n,
                                            input logic [65:0] d, inout logic sat);
        logic [65:0]  mag;
        logic [127:0] q;
        logic signed [65:0] qs;
        mag = (n < 0) ? -n : n;
        q   = (128'(mag) << 16) / 128'(d);
        if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
        qs = $signed({1'b0, q[64:0]});
        return clamp_q16((n < 0) ? -qs : qs, sat);
    endfunction

    task automatic predict_stack(input t_in it);
        t_out r;
        logic sat;
        logic [2:0] st;
        logic signed [65:0] xr, xi, yr, yi, d;
        logic [31:0] rr, ri;
        int t;
        sat = 1'b0;
        st  = ST_OK;
        rr  = '0;
        ri  = '0;
        case (it.op)
            OP_PUSH: begin
                if (stk_count >= DEPTH_MAX) begin
                    st = ST_FULL;
                end else begin
                    stk_re[stk_count] = it.push_real;
                    stk_im[stk_count] = it.push_imag;
                    stk_count++;
                end
            end
            OP_NEG: begin
                if (stk_count < 1) begin
                    st = ST_FEW;
                end else begin
                    t = stk_count - 1;
                    xr = $signed(stk_re[t]);
                    xi = $signed(stk_im[t]);
                    stk_re[t] = clamp_q16(-xr, sat);
                    stk_im[t] = clamp_q16(-xi, sat);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (stk_count < 2) begin
                    st = ST_FEW;
                end else begin
                    t  = stk_count - 1;
                    xr = $signed(stk_re[t-1]);
                    xi = $signed(stk_im[t-1]);
                    yr = $signed(stk_re[t]);
                    yi = $signed(stk_im[t]);
                    case (it.op)
                        OP_ADD: begin
                            rr = clamp_q16(xr + yr, sat);
                            ri = clamp_q16(xi + yi, sat);
                        end
                        OP_SUB: begin
                            rr = clamp_q16(xr - yr, sat);
                            ri = clamp_q16(xi - yi, sat);
                        end
                        OP_MUL: begin
                            rr = clamp_q16((xr * yr - xi * yi) >>> 16, sat);
                            ri = clamp_q16((xr * yi + xi * yr) >>> 16, sat);
                        end
                        default: begin
                            d = yr * yr + yi * yi;
                            if (d == 0) begin
                                st = ST_DIV0;
                            end else begin
                                rr = div_q16(xr * yr + xi * yi, d, sat);
                                ri = div_q16(xi * yr - xr * yi, d, sat);
                            end
                        end
                    endcase
                    if (st == ST_OK) begin
                        stk_re[t-1] = rr;
                        stk_im[t-1] = ri;
                        stk_count--;
                    end
                end
            end
            default: ;
        endcase
        if (sat && st == ST_OK) st = ST_SAT;
        r.top_real = (stk_count > 0) ? stk_re[stk_count-1] : '0;
        r.top_imag = (stk_count > 0) ? stk_im[stk_count-1] : '0;
        r.depth    = 5'(stk_count);
        r.status   = st;
        top_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic add_op(input logic [2:0] op, input logic [31:0] re, input logic [31:0] im);
        t_in it;
        it.op        = op;
        it.push_real = re;
        it.push_imag = im;
        op_queue.push_back(it);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return Q_MAX;
            2:       return Q_MIN;
            3:       return '0;
            4:       return 32'($signed($urandom_range(0, 64)) - 32) << 16;
            default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        endcase
    endfunction

    function automatic int draw_wait(input bit busy_mode);
        return busy_mode ? $urandom_range(0, 16) : 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    = 0;
        end else begin
            nv = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                predict_stack(in_ch.data);
                nv = 1'b0;
                if ($urandom_range(0, 40) == 0) send_busy_mode = ~send_busy_mode;
                send_gap = draw_wait(send_busy_mode);
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else if (op_queue.size() != 0) begin
                    in_ch.data <= op_queue.pop_front();
                    nv = 1'b1;
                end
            end
            in_ch.valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic nr;
        t_out want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall   = 0;
        end else begin
            nr = out_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                if (top_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", 32'(out_ch.data.status), '0);
                end else begin
                    want = top_queue.pop_front();
                    if (out_ch.data.top_real !== want.top_real)
                        report_mismatch("top_real", out_ch.data.top_real, want.top_real);
                    if (out_ch.data.top_imag !== want.top_imag)
                        report_mismatch("top_imag", out_ch.data.top_imag, want.top_imag);
                    if (out_ch.data.depth !== want.depth)
                        report_mismatch("depth", 32'(out_ch.data.depth), 32'(want.depth));
                    if (out_ch.data.status !== want.status)
                        report_mismatch("status", 32'(out_ch.data.status), 32'(want.status));
                end
                if ($urandom_range(0, 40) == 0) recv_busy_mode = ~recv_busy_mode;
                recv_stall = draw_wait(recv_busy_mode);
                if (recv_stall > 0) nr = 1'b0;
            end else if (!nr) begin
                if (recv_stall > 0) recv_stall = recv_stall - 1;
                if (recv_stall == 0) nr = 1'b1;
            end
            out_ch.ready <= nr;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        stk_count      = 0;
        err_count      = 0;
        idle_cycles    = 0;
        send_busy_mode = 1'b1;
        recv_busy_mode = 1'b1;
        i_rst_n        = 1'b0;

        // directed: empty stack, extremes, saturation, zero divisor, full stack
        add_op(OP_ADD, '0, '0);
        add_op(OP_NEG, '0, '0);
        add_op(OP_PUSH, Q_MIN, Q_MAX);
        add_op(OP_DIV, '0, '0);
        add_op(OP_NEG, '0, '0);
        add_op(OP_PUSH, Q_MAX, Q_MIN);
        add_op(OP_ADD, '0, '0);
        add_op(OP_PUSH, Q_MIN, Q_MIN);
        add_op(OP_PUSH, Q_MIN, Q_MIN);
        add_op(OP_MUL, '0, '0);
        add_op(OP_PUSH, '0, '0);
        add_op(OP_DIV, '0, '0);
        add_op(OP_PUSH, Q_ONE, Q_ONE);
        add_op(OP_DIV, '0, '0);
        add_op(OP_PUSH, 32'h00008000, 32'hFFFF8000);
        add_op(OP_SUB, '0, '0);
        add_op(OP_RSV6, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_op(OP_RSV7, '0, '0);
        for (int i = 0; i < DEPTH_MAX; i++) add_op(OP_PUSH, rand_q16(), rand_q16());
        add_op(OP_PUSH, Q_ONE, Q_ONE);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 42)      add_op(OP_PUSH, rand_q16(), rand_q16());
            else if (r < 52) add_op(OP_ADD, $urandom(), $urandom());
            else if (r < 62) add_op(OP_SUB, $urandom(), $urandom());
            else if (r < 73) add_op(OP_MUL, $urandom(), $urandom());
            else if (r < 84) add_op(OP_DIV, $urandom(), $urandom());
            else if (r < 95) add_op(OP_NEG, $urandom(), $urandom());
            else             add_op(($urandom_range(0, 1) != 0) ? OP_RSV7 : OP_RSV6,
                                    $urandom(), $urandom());
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_ch.valid || top_queue.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        if (err_count == 0 && top_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/crsa_pkg.sv
design/crsa_if.sv
design/crsa_div.sv
design/complex_rpn_stack_alu.sv
tb/sv/complex_rpn_stack_alu_test.sv
